// ----- sv/primitive_index_unpacker_assert.svh -----
// Assertion macros used by the primitive index unpacker RTL (pidx_emit).
`ifndef PRIMITIVE_INDEX_UNPACKER_ASSERT_SVH
`define PRIMITIVE_INDEX_UNPACKER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define PIDX_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pidx assertion failed");
// Next-cycle implication, disabled during reset
`define PIDX_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pidx assertion failed");
`else
`define PIDX_ASSERT_IMP(label, clk, rstn, ante, cons)
`define PIDX_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- sv/pidx_pkg.sv -----
// Types and constants of the primitive index unpacker.
`default_nettype none

package pidx_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned JOB_IDX_MAX = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRIM_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_FORMAT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTART_INDEX = 2'd2;

    // Primitive modes
    localparam logic [1:0] MODE_LIST  = 2'd0;
    localparam logic [1:0] MODE_QUADS = 2'd1;
    localparam logic [1:0] MODE_STRIP = 2'd2;
    localparam logic [1:0] MODE_LOOP  = 2'd3;

    // Index formats (codes above FMT_U32_LE are legal and mean direct draw)
    localparam logic [2:0] FMT_AUTO   = 3'd0;
    localparam logic [2:0] FMT_U16_BE = 3'd1;
    localparam logic [2:0] FMT_U16_LE = 3'd2;
    localparam logic [2:0] FMT_U32_BE = 3'd3;
    localparam logic [2:0] FMT_U32_LE = 3'd4;

    localparam logic [31:0] MASK16    = 32'h0000_FFFF;
    localparam logic [31:0] MASK32    = 32'hFFFF_FFFF;
    localparam logic [32:0] COUNT_MAX = 33'h1_FFFF_FFFF;

    typedef struct packed {
        logic [31:0] raw_word;
        logic        last_item;
    } pidx_in_t;

    typedef struct packed {
        logic [31:0] index_value;
        logic        is_index;
        logic        end_of_draw;
        logic [31:0] index_min;
        logic [31:0] index_max;
        logic [32:0] output_count;
        logic        wide_indices;
        logic        direct_draw;
    } pidx_out_t;

    // Results of one input transaction, queued for the output register
    typedef struct packed {
        logic [JOB_IDX_MAX-1:0][31:0] idx_vals;
        logic [2:0]                   idx_cnt;
        logic                         has_sum;
        pidx_out_t                    sum_result;
    } pidx_job_t;

endpackage

`default_nettype wire

// ----- sv/pidx_front.sv -----
// Input side: configuration, index decode, draw state and result list build.
`default_nettype none

module pidx_front
    import pidx_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_wdata,
    input  wire logic                 in_valid,
    input  wire logic                 in_ready,
    input  wire pidx_in_t             in_data,
    output logic                      job_load,
    output pidx_job_t                 job
);

    logic [1:0]  prim_mode_reg;
    logic [2:0]  index_format_reg;
    logic [31:0] restart_index_reg;

    logic [2:0][31:0] window_reg, window_next;
    logic [31:0] first_reg, first_next;
    logic [31:0] vcount_reg, vcount_next;
    logic [31:0] min_reg, min_next;
    logic [31:0] max_reg, max_next;
    logic        seen_reg, seen_next;

    logic        accept;
    logic        valid_fmt;
    logic        fetched;
    logic [31:0] rst_val;
    logic [31:0] n;
    logic [31:0] decoded;
    logic [31:0] cur;
    logic [31:0] n_minus2;
    logic [31:0] quot;
    logic [33:0] cnt_wide;
    logic [32:0] cnt_sat;
    logic        direct;
    logic [3:0][31:0] cand;
    logic [3:0]  take_en;
    logic [JOB_IDX_MAX-1:0][31:0] emit_vals;
    logic [2:0]  emit_cnt;
    pidx_out_t   sum_res;

    assign accept = in_valid && in_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prim_mode_reg     <= MODE_LIST;
            index_format_reg  <= FMT_U16_BE;
            restart_index_reg <= MASK32;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PRIM_MODE:     prim_mode_reg     <= cfg_wdata[1:0];
                CFG_INDEX_FORMAT:  index_format_reg  <= cfg_wdata[2:0];
                CFG_RESTART_INDEX: restart_index_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Format decode and byte order
    always_comb begin
        valid_fmt = (index_format_reg <= FMT_U32_LE);
        fetched   = valid_fmt && (index_format_reg != FMT_AUTO);
        rst_val   = ((index_format_reg == FMT_U16_BE) || (index_format_reg == FMT_U16_LE))
                    ? (restart_index_reg & MASK16) : restart_index_reg;
        n = (vcount_reg != MASK32) ? (vcount_reg + 32'd1) : vcount_reg;
        case (index_format_reg)
            FMT_U16_BE: decoded = {16'd0, in_data.raw_word[7:0], in_data.raw_word[15:8]};
            FMT_U16_LE: decoded = {16'd0, in_data.raw_word[15:0]};
            FMT_U32_BE: decoded = {in_data.raw_word[7:0], in_data.raw_word[15:8],
                                   in_data.raw_word[23:16], in_data.raw_word[31:24]};
            default:    decoded = in_data.raw_word;
        endcase
        cur = (index_format_reg == FMT_AUTO) ? (n - 32'd1) : decoded;
    end

    // Emitted indices and the candidates for the min and max
    always_comb begin
        emit_vals  = '0;
        emit_cnt   = 3'd0;
        cand       = {cur, window_reg[2], window_reg[1], window_reg[0]};
        take_en    = 4'b0000;
        first_next = first_reg;
        if (valid_fmt) begin
            case (prim_mode_reg)
                MODE_LIST: begin
                    if (fetched) begin
                        emit_vals[0] = cur;
                        emit_cnt     = 3'd1;
                        take_en      = 4'b1000;
                    end
                end
                MODE_QUADS: begin
                    if (n[1:0] == 2'b00) begin
                        emit_vals = {cur, window_reg[2], window_reg[0],
                                     window_reg[2], window_reg[1], window_reg[0]};
                        emit_cnt  = 3'd6;
                        take_en   = fetched ? 4'b1111 : 4'b0000;
                    end
                end
                MODE_STRIP: begin
                    if ((n >= 32'd4) && !n[0]) begin
                        emit_vals = {cur, window_reg[1], window_reg[2],
                                     window_reg[2], window_reg[1], window_reg[0]};
                        emit_cnt  = 3'd6;
                        if (fetched) begin
                            take_en = (n == 32'd4) ? 4'b1111 : 4'b1100;
                        end
                    end
                end
                MODE_LOOP: begin
                    if (n == 32'd1) begin
                        first_next = cur;
                    end
                    emit_vals[0] = cur;
                    emit_vals[1] = (n == 32'd1) ? cur : first_reg;
                    emit_cnt     = in_data.last_item ? 3'd2 : 3'd1;
                    take_en      = fetched ? 4'b1000 : 4'b0000;
                end
                default: ;
            endcase
        end
    end

    // Running min and max with restart values left out
    always_comb begin
        min_next  = min_reg;
        max_next  = max_reg;
        seen_next = seen_reg;
        for (int i = 0; i < 4; i++) begin
            if (take_en[i] && (cand[i] != rst_val)) begin
                if (cand[i] < min_next) min_next = cand[i];
                if (cand[i] > max_next) max_next = cand[i];
                seen_next = 1'b1;
            end
        end
    end

    // Output count by primitive mode, saturated to 33 bits
    always_comb begin
        n_minus2 = n - 32'd2;
        case (prim_mode_reg)
            MODE_QUADS: quot = {2'b00, n[31:2]};
            MODE_STRIP: quot = {1'b0, n_minus2[31:1]};
            default:    quot = n;
        endcase
        case (prim_mode_reg)
            MODE_LIST:  cnt_wide = {2'b00, n};
            MODE_QUADS,
            MODE_STRIP: cnt_wide = ({2'b00, quot} << 2) + ({2'b00, quot} << 1);
            MODE_LOOP:  cnt_wide = {2'b00, n} + 34'd1;
            default:    cnt_wide = {2'b00, n};
        endcase
        cnt_sat = (cnt_wide > {1'b0, COUNT_MAX}) ? COUNT_MAX : cnt_wide[32:0];
    end

    // Summary result for the last item of a draw
    always_comb begin
        if (!valid_fmt) begin
            direct = 1'b1;
        end else begin
            case (prim_mode_reg)
                MODE_LIST:  direct = (index_format_reg == FMT_AUTO);
                MODE_QUADS: direct = (n < 32'd4);
                MODE_STRIP: direct = (n <= 32'd3);
                default:    direct = 1'b0;
            endcase
        end
        sum_res             = '0;
        sum_res.end_of_draw = 1'b1;
        if (direct) begin
            sum_res.index_max    = n - 32'd1;
            sum_res.output_count = {1'b0, n};
            sum_res.direct_draw  = 1'b1;
        end else begin
            sum_res.output_count = cnt_sat;
            if (index_format_reg == FMT_AUTO) begin
                sum_res.index_max    = n - 32'd1;
                sum_res.wide_indices = (n > MASK16);
            end else begin
                sum_res.index_min    = seen_next ? min_next : 32'd0;
                sum_res.index_max    = seen_next ? max_next : 32'd0;
                sum_res.wide_indices = (index_format_reg >= FMT_U32_BE);
            end
        end
    end

    // Result list handed to the output register
    assign job = '{idx_vals: emit_vals, idx_cnt: emit_cnt,
                   has_sum: in_data.last_item, sum_result: sum_res};

    assign job_load = accept && (in_data.last_item || (emit_cnt != 3'd0));

    // Draw state; the last item returns it to its reset value
    always_comb begin
        window_next = {cur, window_reg[2], window_reg[1]};
        vcount_next = n;
        if (in_data.last_item) begin
            window_next = '0;
            vcount_next = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            first_reg  <= 32'd0;
            vcount_reg <= 32'd0;
            min_reg    <= MASK32;
            max_reg    <= 32'd0;
            seen_reg   <= 1'b0;
        end else if (accept) begin
            window_reg <= window_next;
            vcount_reg <= vcount_next;
            if (in_data.last_item) begin
                first_reg <= 32'd0;
                min_reg   <= MASK32;
                max_reg   <= 32'd0;
                seen_reg  <= 1'b0;
            end else begin
                first_reg <= first_next;
                min_reg   <= min_next;
                max_reg   <= max_next;
                seen_reg  <= seen_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/pidx_emit.sv -----
// Output side: result register that hands out one transaction's results in order.
`default_nettype none

`include "primitive_index_unpacker_assert.svh"

module pidx_emit
    import pidx_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      job_load,
    input  wire pidx_job_t job,
    output logic           can_take,
    output logic           m_valid,
    input  wire logic      m_ready,
    output pidx_out_t      m_data
);

    pidx_job_t  job_reg;
    logic       job_valid_reg, job_valid_next;
    logic [2:0] pos_reg, pos_next;
    logic [2:0] total;
    logic       last_beat;

    assign total     = job_reg.idx_cnt + {2'b00, job_reg.has_sum};
    assign last_beat = (pos_reg == (total - 3'd1));
    assign m_valid   = job_valid_reg;
    assign can_take  = !job_valid_reg || (m_ready && last_beat);

    // Result select: indices first, then the summary
    always_comb begin
        m_data = '0;
        if (pos_reg < job_reg.idx_cnt) begin
            m_data.index_value = job_reg.idx_vals[pos_reg];
            m_data.is_index    = 1'b1;
        end else begin
            m_data = job_reg.sum_result;
        end
    end

    // Position and occupancy
    always_comb begin
        job_valid_next = job_valid_reg;
        pos_next       = pos_reg;
        if (job_load) begin
            job_valid_next = 1'b1;
            pos_next       = 3'd0;
        end else if (job_valid_reg && m_ready) begin
            if (last_beat) begin
                job_valid_next = 1'b0;
                pos_next       = 3'd0;
            end else begin
                pos_next = pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            pos_reg       <= 3'd0;
        end else begin
            job_valid_reg <= job_valid_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_load) begin
            job_reg <= job;
        end
    end

    `PIDX_ASSERT_IMP(a_job_not_empty, aclk, aresetn, job_valid_reg, total != 3'd0)
    `PIDX_ASSERT_IMP(a_pos_in_range, aclk, aresetn, job_valid_reg, pos_reg < total)
    `PIDX_ASSERT_IMP(a_end_on_last, aclk, aresetn, m_valid && m_data.end_of_draw, last_beat)
    `PIDX_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(pos_reg))

endmodule

`default_nettype wire

// ----- sv/primitive_index_unpacker.sv -----
// Top level of the primitive index unpacker.
`default_nettype none

// Takes one index word per transaction and produces the renderer index stream
// for list, quad, quad strip and line loop draws, plus one summary result
// (min, max, count, index width, direct draw) after the last item. Each input
// transaction is decoded and folded into the draw state in the cycle it is
// accepted; its results, 0 to 7 of them, then leave through a single result
// register at one per cycle while the receiver is ready. The input is ready
// only while that register is empty or the receiver takes its final result,
// so an item that yields results holds the input until they have left and
// an item with no results still waits for the register to drain. This sets
// the pace: with the receiver always ready, lists and line loops run at one item
// per cycle in steady state; quads and quad strips stall while six indices leave.
module primitive_index_unpacker
    import pidx_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire pidx_in_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output pidx_out_t                 m_data
);

    logic      job_load;
    pidx_job_t job;

    pidx_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .job_load  (job_load),
        .job       (job)
    );

    pidx_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .job_load (job_load),
        .job      (job),
        .can_take (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

// ----- test/tb_primitive_index_unpacker.sv -----
// Self-checking testbench for the primitive index unpacker: directed and random draws.
module tb_primitive_index_unpacker;
    import pidx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Register index with no register behind it, and formats that mean direct draw
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [2:0] FMT_NONE_MIN = 3'd5;
    localparam logic [2:0] FMT_NONE_MAX = 3'd7;

    localparam int IDLE_PCT    = 17;
    localparam int DRAIN_GAP   = 8;
    localparam int HOLD_LEN    = 200;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_PRINTS  = 100;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    pidx_in_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    pidx_out_t            m_data;

    primitive_index_unpacker DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #10 aclk = ~aclk;

    // Predictor copy of configuration and draw state
    logic [1:0]  cur_mode;
    logic [2:0]  cur_fmt;
    logic [31:0] restart_cfg;
    logic [31:0] win0, win1, win2;
    logic [31:0] loop_first;
    logic [31:0] vert_count;
    logic [31:0] run_min, run_max;
    logic        seen_index;

    pidx_out_t pending_results[$];
    int        errors = 0;
    int        results_seen = 0;
    int        stall_cycles = 0;

    // Traffic shaping shared with the receiver process
    bit calm = 1'b0;
    bit hold_go = 1'b0;
    int hold_left = 0;

    function automatic logic [31:0] decode_word(input logic [31:0] raw, input logic [2:0] f);
        case (f)
            FMT_U16_BE: return {16'h0000, raw[7:0], raw[15:8]};
            FMT_U16_LE: return raw & MASK16;
            FMT_U32_BE: return {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
            default:    return raw;
        endcase
    endfunction

    task automatic clear_draw_state();
        win0 = '0;
        win1 = '0;
        win2 = '0;
        loop_first = '0;
        vert_count = '0;
        run_min = MASK32;
        run_max = '0;
        seen_index = 1'b0;
    endtask

    task automatic push_index(input logic [31:0] v);
        pidx_out_t r;
        r = '0;
        r.index_value = v;
        r.is_index = 1'b1;
        pending_results.push_back(r);
    endtask

    // Min/max only see indices that differ from the restart value
    task automatic fold_minmax(input logic [31:0] v, input logic [31:0] skip);
        if (v != skip) begin
            if (v < run_min) run_min = v;
            if (v > run_max) run_max = v;
            seen_index = 1'b1;
        end
    endtask

    task automatic predict_draw_item(input pidx_in_t item);
        logic [31:0] n, cur, w0, w1, w2, skip;
        logic        valid_fmt, fetched, direct;
        logic [63:0] cnt;
        pidx_out_t   summary;
        if (vert_count != MASK32) vert_count = vert_count + 1;
        n = vert_count;
        cur = (cur_fmt == FMT_AUTO) ? n - 1 : decode_word(item.raw_word, cur_fmt);
        w0 = win0;
        w1 = win1;
        w2 = win2;
        valid_fmt = cur_fmt <= FMT_U32_LE;
        fetched = valid_fmt && cur_fmt != FMT_AUTO;
        skip = (cur_fmt == FMT_U16_BE || cur_fmt == FMT_U16_LE) ? (restart_cfg & MASK16)
                                                                : restart_cfg;
        if (valid_fmt) begin
            case (cur_mode)
                MODE_LIST: begin
                    if (fetched) begin
                        push_index(cur);
                        fold_minmax(cur, skip);
                    end
                end
                MODE_QUADS: begin
                    // two triangles once every four indices
                    if (n[1:0] == 2'b00) begin
                        push_index(w0); push_index(w1); push_index(w2);
                        push_index(w0); push_index(w2); push_index(cur);
                        if (fetched) begin
                            fold_minmax(w0, skip); fold_minmax(w1, skip);
                            fold_minmax(w2, skip); fold_minmax(cur, skip);
                        end
                    end
                end
                MODE_STRIP: begin
                    // sliding window, every even position from the fourth on
                    if (n >= 4 && !n[0]) begin
                        push_index(w0); push_index(w1); push_index(w2);
                        push_index(w2); push_index(w1); push_index(cur);
                        if (fetched) begin
                            if (n == 4) begin
                                fold_minmax(w0, skip);
                                fold_minmax(w1, skip);
                            end
                            fold_minmax(w2, skip);
                            fold_minmax(cur, skip);
                        end
                    end
                end
                default: begin
                    // line loop closes on its first index
                    if (n == 1) loop_first = cur;
                    push_index(cur);
                    if (fetched) fold_minmax(cur, skip);
                    if (item.last_item) push_index(loop_first);
                end
            endcase
        end
        win0 = w1;
        win1 = w2;
        win2 = cur;

        if (item.last_item) begin
            if (!valid_fmt) direct = 1'b1;
            else begin
                case (cur_mode)
                    MODE_LIST:  direct = (cur_fmt == FMT_AUTO);
                    MODE_QUADS: direct = (n < 4);
                    MODE_STRIP: direct = (n <= 3);
                    default:    direct = 1'b0;
                endcase
            end
            summary = '0;
            summary.end_of_draw = 1'b1;
            if (direct) begin
                summary.index_max = n - 1;
                summary.output_count = {1'b0, n};
                summary.direct_draw = 1'b1;
            end else begin
                case (cur_mode)
                    MODE_LIST:  cnt = 64'(n);
                    MODE_QUADS: cnt = 64'(n >> 2) * 6;
                    MODE_STRIP: cnt = 64'((n - 2) >> 1) * 6;
                    default:    cnt = 64'(n) + 1;
                endcase
                if (cnt > 64'(COUNT_MAX)) cnt = 64'(COUNT_MAX);
                if (cur_fmt == FMT_AUTO) begin
                    summary.index_max = n - 1;
                    summary.wide_indices = (n > MASK16);
                end else begin
                    summary.index_min = seen_index ? run_min : '0;
                    summary.index_max = seen_index ? run_max : '0;
                    summary.wide_indices = (cur_fmt >= FMT_U32_BE);
                end
                summary.output_count = cnt[32:0];
            end
            pending_results.push_back(summary);
            clear_draw_state();
        end
    endtask

    task automatic report_mismatch(input string what);
        errors++;
        // keep the log short when the block is badly off
        if (errors <= MAX_PRINTS) $display("%0t ns mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %h want %h",
                                      results_seen, name, got, want));
    endtask

    // Prediction on input transactions, checking on output transactions, watchdog
    always @(posedge aclk) begin : monitor
        pidx_out_t want;
        bit        moved;
        if (!aresetn) begin
            clear_draw_state();
            cur_mode = MODE_LIST;
            cur_fmt = FMT_U16_BE;
            restart_cfg = MASK32;
            stall_cycles = 0;
        end else begin
            moved = 1'b0;
            if (s_valid && s_ready) begin
                predict_draw_item(s_data);
                moved = 1'b1;
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d unexpected, data %h",
                                              results_seen, m_data));
                end else begin
                    want = pending_results.pop_front();
                    check_field("index_value", 64'(m_data.index_value),
                                64'(want.index_value));
                    check_field("is_index", 64'(m_data.is_index), 64'(want.is_index));
                    check_field("end_of_draw", 64'(m_data.end_of_draw),
                                64'(want.end_of_draw));
                    check_field("index_min", 64'(m_data.index_min), 64'(want.index_min));
                    check_field("index_max", 64'(m_data.index_max), 64'(want.index_max));
                    check_field("output_count", 64'(m_data.output_count),
                                64'(want.output_count));
                    check_field("wide_indices", 64'(m_data.wide_indices),
                                64'(want.wide_indices));
                    check_field("direct_draw", 64'(m_data.direct_draw),
                                64'(want.direct_draw));
                end
                results_seen++;
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PRIM_MODE:     cur_mode = cfg_wdata[1:0];
                    CFG_INDEX_FORMAT:  cur_fmt = cfg_wdata[2:0];
                    CFG_RESTART_INDEX: restart_cfg = cfg_wdata;
                    default: ;
                endcase
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("primitive_index_unpacker test failed");
                $finish;
            end
        end
    end

    // Result receiver: random back-pressure, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_go) begin
            hold_go = 1'b0;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic send_item(input logic [31:0] raw, input logic last);
        pidx_in_t item;
        item.raw_word = raw;
        item.last_item = last;
        @(negedge aclk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop sending, let every expected result drain, then wait out an idle gap
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Unused upper bits of the mode and format words carry random data
    task automatic set_config(input logic [1:0] m, input logic [2:0] f, input logic [31:0] r);
        logic [31:0] noise;
        noise = $urandom;
        write_reg(CFG_PRIM_MODE, {noise[31:2], m});
        noise = $urandom;
        write_reg(CFG_INDEX_FORMAT, {noise[31:3], f});
        write_reg(CFG_RESTART_INDEX, r);
    endtask

    // Raw word: restart hits, small indices, or anything
    function automatic logic [31:0] pick_raw_word(input logic [2:0] f, input logic [31:0] r);
        logic [31:0] v, hi;
        hi = $urandom;
        case ($urandom_range(0, 3))
            0:       v = r;
            1:       v = $urandom_range(0, 15);
            default: return hi;
        endcase
        if (f == FMT_U16_BE || f == FMT_U16_LE) return (hi & ~MASK16) | decode_word(v, f);
        return decode_word(v, f);
    endfunction

    task automatic random_phase(input int n_items);
        int          sent, len, i;
        bit          leave_open;
        logic [1:0]  m;
        logic [2:0]  f;
        logic [31:0] r;
        m = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0:       f = FMT_AUTO;
            9:       f = 3'($urandom_range(FMT_NONE_MIN, FMT_NONE_MAX));
            default: f = 3'($urandom_range(FMT_U16_BE, FMT_U32_LE));
        endcase
        case ($urandom_range(0, 4))
            0:       r = '0;
            1:       r = MASK32;
            2:       r = MASK16;
            3:       r = $urandom_range(0, 15);
            default: r = $urandom;
        endcase
        settle();
        set_config(m, f, r);
        leave_open = ($urandom_range(0, 5) == 0);
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 12);
            for (i = 0; i < len; i++) begin
                // a draw may run on into the next setting
                send_item(pick_raw_word(f, r),
                          (i == len - 1) && !(leave_open && sent + len >= n_items));
            end
            sent += len;
        end
    endtask

    // Reset values: list, u16 big endian, restart 0xFFFF after truncation
    task automatic test_reset_defaults();
        send_item(32'h1234_ABCD, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0001, 1'b1);
    endtask

    task automatic test_big_endian_list();
        settle();
        set_config(MODE_LIST, FMT_U32_BE, 32'h1122_3344);
        send_item(32'h4433_2211, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b1);
    endtask

    // Quads with a partial trailing quad, restart 0
    task automatic test_quads();
        settle();
        set_config(MODE_QUADS, FMT_U16_LE, 32'h0000_0000);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hFFFF_0001, 1'b0);
        send_item(32'h0000_FFFF, 1'b0);
        send_item(32'h1234_0003, 1'b0);
        send_item(32'h5555_0007, 1'b1);
    endtask

    // Four-item strip gives the most results one item can cause
    task automatic test_quad_strip();
        settle();
        set_config(MODE_STRIP, FMT_U32_LE, MASK32);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0001, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h0000_0002, 1'b1);
    endtask

    task automatic test_line_loop_auto();
        settle();
        set_config(MODE_LOOP, FMT_AUTO, 32'h0000_0001);
        send_item($urandom, 1'b0);
        send_item($urandom, 1'b0);
        send_item($urandom, 1'b1);
    endtask

    // Auto list, short quads and the no-index formats all draw directly
    task automatic test_direct_draw();
        settle();
        set_config(MODE_LIST, FMT_AUTO, $urandom);
        send_item($urandom, 1'b0);
        send_item($urandom, 1'b1);
        settle();
        set_config(MODE_QUADS, FMT_U16_BE, $urandom);
        send_item($urandom, 1'b0);
        send_item($urandom, 1'b0);
        send_item($urandom, 1'b1);
        settle();
        set_config(MODE_LOOP, FMT_NONE_MAX, $urandom);
        send_item($urandom, 1'b0);
        send_item($urandom, 1'b1);
    endtask

    // Every index is the restart value, so min and max fall back to zero;
    // a write to the unused register index must change nothing
    task automatic test_restart_only();
        settle();
        set_config(MODE_LIST, FMT_U16_BE, 32'h1234_5678);
        write_reg(CFG_UNUSED, $urandom);
        send_item(32'hABCD_7856, 1'b1);
    endtask

    task automatic test_random_traffic();
        repeat (4) random_phase(6);
    endtask

    task automatic test_calm_stretch();
        settle();
        calm = 1'b1;
        repeat (2) random_phase(6);
        settle();
        calm = 1'b0;
    endtask

    // Receiver holds off while a strip draw keeps coming, so the input stalls
    task automatic test_backpressure();
        int i;
        settle();
        set_config(MODE_STRIP, FMT_U32_LE, $urandom_range(0, 15));
        @(posedge aclk);
        hold_go = 1'b1;
        for (i = 0; i < 16; i++) send_item(pick_raw_word(FMT_U32_LE, restart_cfg), i == 15);
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_big_endian_list();
        test_quads();
        test_quad_strip();
        test_line_loop_auto();
        test_direct_draw();
        test_restart_only();
        test_random_traffic();
        test_calm_stretch();
        test_backpressure();
        settle();

        if (errors == 0) begin
            $display("primitive_index_unpacker test passed");
        end else begin
            $display("primitive_index_unpacker test failed");
        end
        $finish;
    end

endmodule
